### rtl/core/tncl_pkg.sv
package tncl_pkg;

  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  // 10.0 world units of vertical padding, Q16.4, doubled
  localparam logic [21:0] BOX_PAD2   = 22'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_0  = 3'd0,
    REG_PLANE_1  = 3'd1,
    REG_PLANE_2  = 3'd2,
    REG_PLANE_3  = 3'd3,
    REG_PLANE_4  = 3'd4,
    REG_PLANE_5  = 3'd5,
    REG_CAMERA   = 3'd6,
    REG_MIN_SIZE = 3'd7
  } tncl_reg_e;

  typedef struct packed {
    logic signed [19:0] node_x;
    logic signed [19:0] node_z;
    logic        [19:0] node_size;
    logic signed [19:0] min_y;
    logic signed [19:0] max_y;
    logic               is_leaf;
  } tncl_node_t;

  typedef struct packed {
    logic       in_frustum;
    logic [3:0] lod_level;
    logic       descend;
    logic       render;
  } tncl_result_t;

  // box in 1/32 units, handed from cell to cell
  typedef struct packed {
    logic signed [20:0] cx2;
    logic signed [20:0] cz2;
    logic signed [20:0] cy2;
    logic        [19:0] ex2;
    logic signed [21:0] ey2;
    logic               vis;
  } tncl_box_t;

endpackage

### rtl/core/tncl_plane_cell.sv
module tncl_plane_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [63:0]         plane_i,
  input  logic                valid_i,
  input  tncl_pkg::tncl_box_t data_i,
  output logic                up_ready_o,
  input  logic                down_ready_i,
  output logic                valid_o,
  output tncl_pkg::tncl_box_t data_o
);

  logic                valid_q;
  tncl_pkg::tncl_box_t data_q, data_d;
  logic                en;

  logic signed [11:0] nx, ny, nz;
  logic signed [27:0] w;
  logic signed [22:0] cx, cy, cz, ex, ey;
  logic signed [22:0] vx, vy, vz;
  logic signed [41:0] px, py, pz, wsc, plane_dist;

  assign en         = !valid_q || down_ready_i;
  assign up_ready_o = en;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_comb begin
    nx  = plane_i[11:0];
    ny  = plane_i[23:12];
    nz  = plane_i[35:24];
    w   = plane_i[63:36];
    cx  = 23'(data_i.cx2);
    cy  = 23'(data_i.cy2);
    cz  = 23'(data_i.cz2);
    ex  = $signed({3'b000, data_i.ex2});
    ey  = 23'(data_i.ey2);
    // positive vertex: pick the box corner along each normal's sign
    vx  = nx[11] ? cx - ex : cx + ex;
    vy  = ny[11] ? cy - ey : cy + ey;
    vz  = nz[11] ? cz - ex : cz + ex;
    px  = nx * vx;
    py  = ny * vy;
    pz  = nz * vz;
    wsc = {{3{w[27]}}, w, 11'b0};
    plane_dist = px + py + pz + wsc;
    data_d     = data_i;
    data_d.vis = data_i.vis & ~plane_dist[41];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/core/tncl_range.sv
module tncl_range #(
  parameter int unsigned LOD_LEVELS = 8
) (
  input  logic                 clk_i,
  input  logic [tncl_pkg::NUM_PLANES-1:0] en_i,
  input  tncl_pkg::tncl_node_t node_i,
  input  logic [59:0]          camera_i,
  input  logic [19:0]          min_size_i,
  output logic [3:0]           lod_o,
  output logic                 desc_o
);

  logic signed [21:0] kx2, ky2, kz2, cx2, cy2, cz2;
  logic signed [21:0] dx, dy, dz;
  logic signed [43:0] sqx, sqy, sqz;
  logic signed [43:0] lsq;
  logic signed [22:0] lim_s;

  // stage 0
  logic [42:0]        dxx_q, dzz_q;
  logic signed [21:0] dy_q;
  logic [19:0]        size0_q;
  logic               leaf0_q;
  // stage 1
  logic [43:0]        hz1_q;
  logic [42:0]        dyy_q;
  logic [19:0]        size1_q;
  logic               leaf1_q;
  // stage 2
  logic [44:0]        d3_q;
  logic [43:0]        hz2_q;
  logic [39:0]        m2_q;
  logic [21:0]        lim_q;
  logic               leaf2_q;
  // stage 3
  logic [43:0]        lsq_q, hz3_q;
  logic [3:0]         lod3_q, lod_d;
  logic               leaf3_q;
  // stages 4 and 5
  logic [3:0]         lod4_q, lod5_q;
  logic               desc4_q, desc5_q;

  always_comb begin
    kx2 = 22'($signed({camera_i[19:0], 1'b0}));
    ky2 = 22'($signed({camera_i[39:20], 1'b0}));
    kz2 = 22'($signed({camera_i[59:40], 1'b0}));
    cx2 = 22'($signed({node_i.node_x, 1'b0}));
    cz2 = 22'($signed({node_i.node_z, 1'b0}));
    cy2 = 22'(node_i.min_y) + 22'(node_i.max_y);
    dx  = kx2 - cx2;
    dy  = ky2 - cy2;
    dz  = kz2 - cz2;
    sqx = dx * dx;
    sqz = dz * dz;
    sqy = dy_q * dy_q;
    lim_s = $signed({1'b0, lim_q});
    lsq   = lim_s * lim_s;
  end

  // lowest level whose threshold min_size * 2^(L-i) lies beyond the distance
  always_comb begin
    lod_d = 4'(LOD_LEVELS - 1);
    for (int i = LOD_LEVELS - 1; i >= 0; i--) begin
      if ((d3_q >> (2 * (LOD_LEVELS - i + 1))) < 45'(m2_q)) begin
        lod_d = 4'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dxx_q   <= sqx[42:0];
      dzz_q   <= sqz[42:0];
      dy_q    <= dy;
      size0_q <= node_i.node_size;
      leaf0_q <= node_i.is_leaf;
    end
    if (en_i[1]) begin
      hz1_q   <= 44'(dxx_q) + 44'(dzz_q);
      dyy_q   <= sqy[42:0];
      size1_q <= size0_q;
      leaf1_q <= leaf0_q;
    end
    if (en_i[2]) begin
      d3_q    <= 45'(hz1_q) + 45'(dyy_q);
      hz2_q   <= hz1_q;
      m2_q    <= min_size_i * min_size_i;
      lim_q   <= 22'(size1_q) + 22'({size1_q, 1'b0});
      leaf2_q <= leaf1_q;
    end
    if (en_i[3]) begin
      lsq_q   <= lsq[43:0];
      hz3_q   <= hz2_q;
      lod3_q  <= lod_d;
      leaf3_q <= leaf2_q;
    end
    if (en_i[4]) begin
      lod4_q  <= lod3_q;
      desc4_q <= !leaf3_q && (hz3_q < lsq_q);
    end
    if (en_i[5]) begin
      lod5_q  <= lod4_q;
      desc5_q <= desc4_q;
    end
  end

  assign lod_o  = lod5_q;
  assign desc_o = desc5_q;

endmodule

### rtl/core/terrain_node_cull_lod.sv
// Terrain quadtree node classifier.
// Input channel (in_valid_i/in_ready_o, in_word_i) takes one node word per
// cycle while in_ready_o is high: center x/z, edge size, height range and
// leaf flag. Output channel (out_valid_o/out_ready_i, out_word_o) returns
// one result word per node: frustum pass, LOD level, descend and render
// flags, in input order. The node flows through a row of six plane cells,
// one frustum plane each; a side pipeline of the same depth forms camera
// distances, the LOD pick and the descend test. Throughput is one node per
// cycle while out_ready_i stays high, set by the cell row.
// Each cell holds its word while the next one is full and stalled, so with
// out_ready_i low up to six words are buffered; in_ready_o falls only when
// every cell is full. Empty cells are filled even while the output waits.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes planes 0..5, the
// camera position and the minimum node size; write only while no node is
// in flight. Reset empties the row and sets planes and camera to zero and
// the minimum node size to 256 (16.0 world units).
module terrain_node_cull_lod #(
  parameter int unsigned LOD_LEVELS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tncl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tncl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tncl_pkg::tncl_node_t                 in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tncl_pkg::tncl_result_t               out_word_o
);

  localparam int unsigned NP = tncl_pkg::NUM_PLANES;

  logic [63:0] plane_q [NP];
  logic [59:0] camera_q;
  logic [19:0] min_size_q;

  logic [NP:0]         stage_v;
  logic [NP:0]         stage_rdy;
  tncl_pkg::tncl_box_t stage_d [NP+1];
  tncl_pkg::tncl_box_t box_in;

  logic [3:0] lod;
  logic       desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NP; p++) begin
        plane_q[p] <= '0;
      end
      camera_q   <= '0;
      min_size_q <= 20'd256;
    end else if (cfg_we_i) begin
      unique case (tncl_pkg::tncl_reg_e'(cfg_idx_i))
        tncl_pkg::REG_PLANE_0:  plane_q[0] <= cfg_data_i;
        tncl_pkg::REG_PLANE_1:  plane_q[1] <= cfg_data_i;
        tncl_pkg::REG_PLANE_2:  plane_q[2] <= cfg_data_i;
        tncl_pkg::REG_PLANE_3:  plane_q[3] <= cfg_data_i;
        tncl_pkg::REG_PLANE_4:  plane_q[4] <= cfg_data_i;
        tncl_pkg::REG_PLANE_5:  plane_q[5] <= cfg_data_i;
        tncl_pkg::REG_CAMERA:   camera_q   <= cfg_data_i[59:0];
        tncl_pkg::REG_MIN_SIZE: min_size_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // box in 1/32 units so the halving of size and height is exact
  always_comb begin
    box_in.cx2 = {in_word_i.node_x, 1'b0};
    box_in.cz2 = {in_word_i.node_z, 1'b0};
    box_in.cy2 = 21'(in_word_i.min_y) + 21'(in_word_i.max_y);
    box_in.ex2 = in_word_i.node_size;
    box_in.ey2 = 22'(in_word_i.max_y) - 22'(in_word_i.min_y) + $signed(tncl_pkg::BOX_PAD2);
    box_in.vis = 1'b1;
  end

  assign stage_d[0]    = box_in;
  assign stage_v[0]    = in_valid_i;
  assign stage_rdy[NP] = out_ready_i;
  assign in_ready_o    = stage_rdy[0];

  for (genvar k = 0; k < NP; k++) begin : g_cell
    tncl_plane_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .plane_i      (plane_q[k]),
      .valid_i      (stage_v[k]),
      .data_i       (stage_d[k]),
      .up_ready_o   (stage_rdy[k]),
      .down_ready_i (stage_rdy[k+1]),
      .valid_o      (stage_v[k+1]),
      .data_o       (stage_d[k+1])
    );
  end

  tncl_range #(
    .LOD_LEVELS (LOD_LEVELS)
  ) u_range (
    .clk_i      (clk_i),
    .en_i       (stage_rdy[NP-1:0]),
    .node_i     (in_word_i),
    .camera_i   (camera_q),
    .min_size_i (min_size_q),
    .lod_o      (lod),
    .desc_o     (desc)
  );

  always_comb begin
    out_word_o.in_frustum = stage_d[NP].vis;
    out_word_o.lod_level  = stage_d[NP].vis ? lod : 4'd0;
    out_word_o.descend    = stage_d[NP].vis & desc;
    out_word_o.render     = stage_d[NP].vis & ~desc;
  end

  assign out_valid_o = stage_v[NP];

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped under stall");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&stage_v[NP:1]) && !out_ready_i)
    else $error("input blocked with an empty cell");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> stage_v[1])
    else $error("accepted word missing from first cell");

  a_culled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.in_frustum |->
      out_word_o.lod_level == 4'd0 && !out_word_o.descend && !out_word_o.render)
    else $error("culled node carries LOD or draw flags");

  a_visible_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.in_frustum |->
      out_word_o.descend != out_word_o.render)
    else $error("visible node must either descend or render");

endmodule
